// File: hw/rtl/chr_pkg.sv
// Shared types and constants of the chord history ring.
package chr_pkg;

  localparam int MaxDepth = 64;
  localparam int MaxNotes = 8;
  localparam int NoteW    = 8;
  localparam int AddrW    = $clog2(MaxDepth);
  localparam int CntW     = $clog2(MaxDepth + 1);
  localparam int CfgW     = 7;
  localparam int CfgIdxW  = 2;
  localparam int CountW   = 4;
  localparam int WidthW   = 4;

  typedef enum logic [CfgIdxW-1:0] {
    CfgDepth   = 2'd0,
    CfgReverse = 2'd1,
    CfgWidth   = 2'd2,
    CfgReplay  = 2'd3
  } cfg_idx_e;

  typedef logic [MaxNotes-1:0][NoteW-1:0] chord_t;

  typedef struct packed {
    logic [CountW-1:0] note_count;
    logic [NoteW-1:0]  in_note_0;
    logic [NoteW-1:0]  in_note_1;
    logic [NoteW-1:0]  in_note_2;
    logic [NoteW-1:0]  in_note_3;
    logic [NoteW-1:0]  in_note_4;
    logic [NoteW-1:0]  in_note_5;
    logic [NoteW-1:0]  in_note_6;
    logic [NoteW-1:0]  in_note_7;
  } in_req_t;

  typedef struct packed {
    logic [NoteW-1:0] out_note_0;
    logic [NoteW-1:0] out_note_1;
    logic [NoteW-1:0] out_note_2;
    logic [NoteW-1:0] out_note_3;
    logic [NoteW-1:0] out_note_4;
    logic [NoteW-1:0] out_note_5;
    logic [NoteW-1:0] out_note_6;
    logic [NoteW-1:0] out_note_7;
  } out_rsp_t;

  // Ring access issued by the controller for one accepted request.
  typedef struct packed {
    logic             emit;
    logic             replay;
    logic             we;
    logic             re;
    logic [AddrW-1:0] addr;
    chord_t           wdata;
  } access_t;

  typedef struct packed {
    logic [CntW-1:0] fill;
    logic [CntW-1:0] depth;
  } status_t;

endpackage

// File: hw/rtl/chr_store.sv
// Chord storage: single-port synchronous memory with registered read data.
module chr_store (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic                  re_i,
  input  logic [chr_pkg::AddrW-1:0] addr_i,
  input  chr_pkg::chord_t       wdata_i,
  output chr_pkg::chord_t       rdata_o
);
  import chr_pkg::*;

  chord_t mem_q [MaxDepth];
  chord_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/chr_ctrl.sv
// Configuration registers, ring position and fill count, and access generation.
module chr_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [chr_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [chr_pkg::CfgW-1:0]    cfg_data_i,
  input  logic                        in_acc_i,
  input  logic [chr_pkg::CountW-1:0]  note_count_i,
  input  chr_pkg::chord_t             in_chord_i,
  output chr_pkg::access_t            acc_o,
  output chr_pkg::status_t            status_o,
  output logic [chr_pkg::WidthW-1:0]  width_o
);
  import chr_pkg::*;

  logic [CfgW-1:0]   depth_q;
  logic              reverse_q;
  logic [WidthW-1:0] width_q;
  logic              replay_q;
  logic              pos_vld_q, pos_vld_d;
  logic [AddrW-1:0]  pos_q, pos_d;
  logic [CntW-1:0]   fill_q, fill_d;

  logic [CntW-1:0]   depth_eff;
  logic [WidthW-1:0] width_eff;
  logic [CntW-1:0]   pos_inc;
  logic [CntW-1:0]   fill_m1;
  logic [AddrW-1:0]  rec_slot;
  logic [AddrW-1:0]  fwd_slot;
  logic [AddrW-1:0]  rev_cur;
  logic [AddrW-1:0]  rev_next;
  logic              active;
  chord_t            wdata;

  assign depth_eff = (CntW'(depth_q) > CntW'(MaxDepth)) ? CntW'(MaxDepth) : CntW'(depth_q);
  assign width_eff = (width_q == '0) ? WidthW'(1) :
                     (width_q > WidthW'(MaxNotes)) ? WidthW'(MaxNotes) : width_q;

  assign pos_inc = CntW'(pos_q) + CntW'(1);
  assign fill_m1 = fill_q - CntW'(1);

  assign rec_slot = (!pos_vld_q || pos_inc >= depth_eff) ? '0 : pos_inc[AddrW-1:0];
  assign fwd_slot = (!pos_vld_q || pos_inc >= fill_q) ? '0 : pos_inc[AddrW-1:0];
  // Newest-first replay reads the current entry, then steps back within the fill.
  assign rev_cur  = (!pos_vld_q || CntW'(pos_q) >= fill_q) ? fill_m1[AddrW-1:0] : pos_q;
  assign rev_next = (rev_cur == '0) ? fill_m1[AddrW-1:0] : rev_cur - AddrW'(1);

  assign active = in_acc_i && (depth_eff != '0) && (note_count_i != '0) &&
                  (!replay_q || fill_q != '0);

  always_comb begin
    for (int i = 0; i < MaxNotes; i++) begin
      wdata[i] = (WidthW'(i) < width_eff && CountW'(i) < note_count_i) ? in_chord_i[i] : '0;
    end
  end

  always_comb begin
    acc_o.emit   = active;
    acc_o.replay = replay_q;
    acc_o.we     = active && !replay_q;
    acc_o.re     = active && replay_q;
    acc_o.wdata  = wdata;
    if (!replay_q) begin
      acc_o.addr = rec_slot;
    end else if (reverse_q) begin
      acc_o.addr = rev_cur;
    end else begin
      acc_o.addr = fwd_slot;
    end
  end

  always_comb begin
    pos_vld_d = pos_vld_q;
    pos_d     = pos_q;
    fill_d    = fill_q;
    if (active) begin
      pos_vld_d = 1'b1;
      if (!replay_q) begin
        pos_d = rec_slot;
        if (CntW'(rec_slot) == fill_q && fill_q < depth_eff) begin
          fill_d = fill_q + CntW'(1);
        end
      end else if (reverse_q) begin
        pos_d = rev_next;
      end else begin
        pos_d = fwd_slot;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q   <= '0;
      reverse_q <= 1'b0;
      width_q   <= WidthW'(1);
      replay_q  <= 1'b0;
      pos_vld_q <= 1'b0;
      pos_q     <= '0;
      fill_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgDepth: begin
          depth_q   <= cfg_data_i;
          pos_vld_q <= 1'b0;
          fill_q    <= '0;
        end
        CfgReverse: begin
          reverse_q <= cfg_data_i[0];
          pos_vld_q <= 1'b0;
          fill_q    <= '0;
        end
        CfgWidth: begin
          width_q   <= cfg_data_i[WidthW-1:0];
          pos_vld_q <= 1'b0;
          fill_q    <= '0;
        end
        CfgReplay: begin
          replay_q <= cfg_data_i[0];
        end
        default: begin
        end
      endcase
    end else begin
      pos_vld_q <= pos_vld_d;
      pos_q     <= pos_d;
      fill_q    <= fill_d;
    end
  end

  assign status_o.fill  = fill_q;
  assign status_o.depth = depth_eff;
  assign width_o        = width_eff;

endmodule

// File: hw/rtl/chord_history_ring_replay.sv
// Top level of the chord history ring: controller, chord memory and output stage.
//
// Each accepted request makes one access to a single-port chord memory: a write in record
// mode, a read in replay mode. Position and fill count sit in flip-flops next to the
// memory and are updated in the cycle of acceptance, so a request can be accepted on
// every clock unless the middle stage stalls. A result passes through the middle stage
// (registered memory read in replay, captured chord in record) and the output register,
// and the block sustains one request per cycle while the output side keeps taking results.
// Requests that give no result (depth zero, note count zero, replay on an empty ring)
// are accepted and dropped without touching state. The user must see that configuration is
// written only while the block is idle; the block itself does not enforce this.
module chord_history_ring_replay (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [chr_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [chr_pkg::CfgW-1:0]    cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  chr_pkg::in_req_t            in_req_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output chr_pkg::out_rsp_t           out_rsp_o
);
  import chr_pkg::*;

  access_t           acc;
  status_t           status;
  logic [WidthW-1:0] width_eff;
  chord_t            in_chord;
  chord_t            rdata;
  logic              in_acc;

  logic              s1_valid_q, s1_valid_d;
  logic              s1_replay_q;
  chord_t            s1_data_q;
  logic              s1_move;
  logic              out_valid_q, out_valid_d;
  chord_t            out_q, res_chord;

  assign in_chord[0] = in_req_i.in_note_0;
  assign in_chord[1] = in_req_i.in_note_1;
  assign in_chord[2] = in_req_i.in_note_2;
  assign in_chord[3] = in_req_i.in_note_3;
  assign in_chord[4] = in_req_i.in_note_4;
  assign in_chord[5] = in_req_i.in_note_5;
  assign in_chord[6] = in_req_i.in_note_6;
  assign in_chord[7] = in_req_i.in_note_7;

  assign s1_move    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_move;
  assign in_acc     = in_valid_i && in_ready_o;

  chr_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_acc_i     (in_acc),
    .note_count_i (in_req_i.note_count),
    .in_chord_i   (in_chord),
    .acc_o        (acc),
    .status_o     (status),
    .width_o      (width_eff)
  );

  chr_store u_store (
    .clk_i   (clk_i),
    .we_i    (acc.we),
    .re_i    (acc.re),
    .addr_i  (acc.addr),
    .wdata_i (acc.wdata),
    .rdata_o (rdata)
  );

  // The read data stays put while the stage stalls, since reads only happen on acceptance.
  always_comb begin
    for (int i = 0; i < MaxNotes; i++) begin
      res_chord[i] = (WidthW'(i) < width_eff) ? (s1_replay_q ? rdata[i] : s1_data_q[i]) : '0;
    end
  end

  assign s1_valid_d  = acc.emit || (s1_valid_q && !s1_move);
  assign out_valid_d = s1_move || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc.emit) begin
      s1_replay_q <= acc.replay;
      s1_data_q   <= acc.wdata;
    end
    if (s1_move) begin
      out_q <= res_chord;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign out_rsp_o.out_note_0 = out_q[0];
  assign out_rsp_o.out_note_1 = out_q[1];
  assign out_rsp_o.out_note_2 = out_q[2];
  assign out_rsp_o.out_note_3 = out_q[3];
  assign out_rsp_o.out_note_4 = out_q[4];
  assign out_rsp_o.out_note_5 = out_q[5];
  assign out_rsp_o.out_note_6 = out_q[6];
  assign out_rsp_o.out_note_7 = out_q[7];

  // The fill count never runs past the depth in use.
  assert property (@(posedge clk_i) disable iff (!rst_ni) status.fill <= status.depth)
    else $error("fill count exceeds ring depth");

  // A memory access is either a write or a read, never both.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(acc.we && acc.re))
    else $error("simultaneous ring write and read");

  // A replay read lands in the middle stage on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) acc.re |=> s1_valid_q && s1_replay_q)
    else $error("replay read did not reach the middle stage");

  // Accesses are only issued for accepted requests.
  assert property (@(posedge clk_i) disable iff (!rst_ni) acc.emit |-> in_acc)
    else $error("ring access without an accepted request");

endmodule
